// ----- sv/csb_pkg.sv -----
// Package for the C source blanker with loop depth.
// Holds the request and result types, character codes and the lexer and
// keyword tables. No dependencies.
package csb_pkg;

    localparam int CHAR_W = 8;
    localparam int LOOP_W = 7;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last_char;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic [LOOP_W-1:0] loop_depth;
        logic              end_of_text;
        logic              nest_overflow;
    } out_item_t;

    // Control from the sequencer to the lexer.
    typedef struct packed {
        logic step;
        logic clear;
        logic consumed;
        logic has_next;
    } lex_ctl_t;

    // Control from the sequencer to the depth tracker.
    typedef struct packed {
        logic step;
        logic clear;
    } depth_ctl_t;

    typedef enum logic [4:0] {
        MODE_CODE  = 5'b00001,
        MODE_BLOCK = 5'b00010,
        MODE_LINE  = 5'b00100,
        MODE_STR   = 5'b01000,
        MODE_CHR   = 5'b10000
    } lex_mode_t;

    typedef enum logic [2:0] {
        HDR_NONE  = 3'b001,
        HDR_COND  = 3'b010,
        HDR_AFTER = 3'b100
    } hdr_phase_t;

    typedef enum logic [2:0] {
        PH_RUN  = 3'b001,
        PH_TAIL = 3'b010,
        PH_END  = 3'b100
    } seq_phase_t;

    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_F      = 8'h66;
    localparam logic [CHAR_W-1:0] CH_W      = 8'h77;

    // Keyword matcher: progress codes for "for" and "while".
    localparam logic [2:0] KW_IDLE = 3'd0;
    localparam logic [2:0] KW_F    = 3'd1;
    localparam logic [2:0] KW_FO   = 3'd2;
    localparam logic [2:0] KW_W    = 3'd3;
    localparam logic [2:0] KW_WH   = 3'd4;
    localparam logic [2:0] KW_WHI  = 3'd5;
    localparam logic [2:0] KW_WHIL = 3'd6;
    localparam logic [2:0] KW_DONE = 3'd7;

    function automatic logic [CHAR_W-1:0] kw_want(input logic [2:0] k);
        logic [CHAR_W-1:0] c;
        case (k)
            KW_F:    c = 8'h6F; // o
            KW_FO:   c = 8'h72; // r
            KW_W:    c = 8'h68; // h
            KW_WH:   c = 8'h69; // i
            KW_WHI:  c = 8'h6C; // l
            KW_WHIL: c = 8'h65; // e
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_after(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            KW_F:    n = KW_FO;
            KW_FO:   n = KW_DONE;
            KW_W:    n = KW_WH;
            KW_WH:   n = KW_WHI;
            KW_WHI:  n = KW_WHIL;
            KW_WHIL: n = KW_DONE;
            default: n = KW_IDLE;
        endcase
        return n;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c >= 8'h09 && c <= 8'h0D) || (c >= 8'h1C && c <= 8'h20);
    endfunction

    function automatic logic is_ident(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

endpackage

// ----- sv/csb_lexer.sv -----
// Five-mode lexer that blanks comments, literal contents and escapes.
// Holds the lexer mode register; uses csb_pkg.
module csb_lexer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  csb_pkg::lex_ctl_t           ctl,
    input  logic [csb_pkg::CHAR_W-1:0]  cur,
    input  logic [csb_pkg::CHAR_W-1:0]  nxt,
    output logic [csb_pkg::CHAR_W-1:0]  blanked,
    output logic                        eat
);

    csb_pkg::lex_mode_t mode_reg;
    csb_pkg::lex_mode_t mode_next;
    csb_pkg::lex_mode_t mode_calc;

    always_comb
    begin
        blanked   = cur;
        eat       = 1'b0;
        mode_calc = mode_reg;
        if (ctl.consumed)
        begin
            blanked = csb_pkg::CH_SPACE;
        end
        else if (cur == csb_pkg::CH_NL)
        begin
            if (mode_reg == csb_pkg::MODE_LINE)
            begin
                mode_calc = csb_pkg::MODE_CODE;
            end
        end
        else
        begin
            case (mode_reg)
                csb_pkg::MODE_CODE:
                begin
                    if (cur == csb_pkg::CH_SLASH && ctl.has_next &&
                        (nxt == csb_pkg::CH_STAR || nxt == csb_pkg::CH_SLASH))
                    begin
                        mode_calc = (nxt == csb_pkg::CH_STAR) ? csb_pkg::MODE_BLOCK
                                                              : csb_pkg::MODE_LINE;
                        eat       = 1'b1;
                        blanked   = csb_pkg::CH_SPACE;
                    end
                    else if (cur == csb_pkg::CH_DQUOTE)
                    begin
                        mode_calc = csb_pkg::MODE_STR;
                    end
                    else if (cur == csb_pkg::CH_SQUOTE)
                    begin
                        mode_calc = csb_pkg::MODE_CHR;
                    end
                end
                csb_pkg::MODE_BLOCK:
                begin
                    blanked = csb_pkg::CH_SPACE;
                    if (cur == csb_pkg::CH_STAR && ctl.has_next && nxt == csb_pkg::CH_SLASH)
                    begin
                        mode_calc = csb_pkg::MODE_CODE;
                        eat       = 1'b1;
                    end
                end
                csb_pkg::MODE_LINE:
                begin
                    blanked = csb_pkg::CH_SPACE;
                end
                csb_pkg::MODE_STR, csb_pkg::MODE_CHR:
                begin
                    blanked = csb_pkg::CH_SPACE;
                    if (cur == csb_pkg::CH_BSLASH)
                    begin
                        // An escape swallows the next byte unless it is a newline.
                        eat = ctl.has_next && (nxt != csb_pkg::CH_NL);
                    end
                    else if ((mode_reg == csb_pkg::MODE_STR && cur == csb_pkg::CH_DQUOTE) ||
                             (mode_reg == csb_pkg::MODE_CHR && cur == csb_pkg::CH_SQUOTE))
                    begin
                        mode_calc = csb_pkg::MODE_CODE;
                        blanked   = cur;
                    end
                end
                default:
                begin
                    mode_calc = csb_pkg::MODE_CODE;
                end
            endcase
        end
    end

    always_comb
    begin
        if (ctl.clear)
        begin
            mode_next = csb_pkg::MODE_CODE;
        end
        else if (ctl.step)
        begin
            mode_next = mode_calc;
        end
        else
        begin
            mode_next = mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= csb_pkg::MODE_CODE;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ----- sv/csb_depth.sv -----
// Loop depth tracker: keyword matcher, header parser, paren balance and
// brace-kind stack with its top held in registers. Uses csb_pkg.
module csb_depth
#(
    parameter int STACK_DEPTH = 64,
    parameter int PAREN_MAX   = 255
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  csb_pkg::depth_ctl_t         ctl,
    input  logic [csb_pkg::CHAR_W-1:0]  blanked,
    output logic [csb_pkg::LOOP_W-1:0]  loop_depth,
    output logic [csb_pkg::LOOP_W-1:0]  final_depth,
    output logic                        overflow
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int PW = $clog2(PAREN_MAX + 1);

    csb_pkg::hdr_phase_t hdr_reg, hdr_next;
    logic [2:0]          kw_reg, kw_next;
    logic [PW-1:0]       paren_reg, paren_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic                prev_ident_reg, prev_ident_next;
    logic                ovf_reg, ovf_next;
    logic [CW-1:0]       count_reg, count_next, count_calc;
    logic                top_kind_reg, top_kind_next;
    logic                below_reg;

    // Entries under the top of the stack.
    logic                kinds_mem [STACK_DEPTH];

    logic                plain;
    logic                push;
    logic                push_kind;
    logic                pop;
    logic                full;
    logic [DW-1:0]       depth_rep;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    logic [CW-1:0]       raddr_full;

    assign full = (count_reg >= CW'(STACK_DEPTH));

    always_comb
    begin
        hdr_next        = hdr_reg;
        kw_next         = kw_reg;
        paren_next      = paren_reg;
        depth_next      = depth_reg;
        ovf_next        = ovf_reg;
        plain           = 1'b1;
        push            = 1'b0;
        push_kind       = 1'b0;
        pop             = 1'b0;
        depth_rep       = depth_reg;

        if (hdr_reg == csb_pkg::HDR_COND)
        begin
            if (blanked == csb_pkg::CH_LPAREN)
            begin
                if (paren_reg < PW'(PAREN_MAX))
                begin
                    paren_next = paren_reg + PW'(1);
                end
            end
            else if (blanked == csb_pkg::CH_RPAREN)
            begin
                if (paren_reg != '0)
                begin
                    paren_next = paren_reg - PW'(1);
                end
                if (paren_next == '0)
                begin
                    hdr_next = csb_pkg::HDR_AFTER;
                end
            end
            plain = 1'b0;
        end
        else if (hdr_reg == csb_pkg::HDR_AFTER)
        begin
            if (csb_pkg::is_space(blanked))
            begin
                plain = 1'b0;
            end
            else
            begin
                hdr_next = csb_pkg::HDR_NONE;
                if (blanked == csb_pkg::CH_LBRACE)
                begin
                    push      = 1'b1;
                    push_kind = 1'b1;
                    plain     = 1'b0;
                    if (!full)
                    begin
                        depth_next = depth_reg + DW'(1);
                    end
                    depth_rep = depth_next;
                end
            end
        end
        else if (kw_reg == csb_pkg::KW_DONE)
        begin
            if (csb_pkg::is_space(blanked))
            begin
                plain = 1'b0;
            end
            else if (blanked == csb_pkg::CH_LPAREN)
            begin
                kw_next    = csb_pkg::KW_IDLE;
                hdr_next   = csb_pkg::HDR_COND;
                paren_next = PW'(1);
                plain      = 1'b0;
            end
            else
            begin
                kw_next = csb_pkg::KW_IDLE;
            end
        end
        else if (kw_reg != csb_pkg::KW_IDLE)
        begin
            kw_next = (blanked == csb_pkg::kw_want(kw_reg)) ? csb_pkg::kw_after(kw_reg)
                                                            : csb_pkg::KW_IDLE;
        end

        if (plain)
        begin
            if (kw_next == csb_pkg::KW_IDLE && !prev_ident_reg)
            begin
                if (blanked == csb_pkg::CH_F)
                begin
                    kw_next = csb_pkg::KW_F;
                end
                else if (blanked == csb_pkg::CH_W)
                begin
                    kw_next = csb_pkg::KW_W;
                end
            end
            if (blanked == csb_pkg::CH_LBRACE)
            begin
                push = 1'b1;
            end
            else if (blanked == csb_pkg::CH_RBRACE && count_reg != '0)
            begin
                pop = 1'b1;
                if (top_kind_reg && depth_reg != '0)
                begin
                    depth_next = depth_reg - DW'(1);
                end
            end
        end

        if (push && full)
        begin
            ovf_next = 1'b1;
        end
        prev_ident_next = csb_pkg::is_ident(blanked);
    end

    // Stack pointer and top-of-stack updates.
    always_comb
    begin
        count_calc    = count_reg;
        top_kind_next = top_kind_reg;
        if (push && !full)
        begin
            count_calc    = count_reg + CW'(1);
            top_kind_next = push_kind;
        end
        else if (pop)
        begin
            count_calc    = count_reg - CW'(1);
            top_kind_next = below_reg;
        end

        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.step)
        begin
            count_next = count_calc;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // The old top moves into memory on a push; the entry under the new top
    // is always prefetched so that a pop can take it at once.
    assign we         = ctl.step && !ctl.clear && push && !full && (count_reg != '0);
    assign waddr      = AW'(count_reg - CW'(1));
    assign raddr_full = count_next - CW'(2);
    assign raddr      = raddr_full[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            kinds_mem[waddr] <= top_kind_reg;
        end
        if (we && waddr == raddr)
        begin
            below_reg <= top_kind_reg;
        end
        else
        begin
            below_reg <= kinds_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg        <= csb_pkg::HDR_NONE;
            kw_reg         <= csb_pkg::KW_IDLE;
            paren_reg      <= '0;
            depth_reg      <= '0;
            prev_ident_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            count_reg      <= '0;
            top_kind_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (ctl.clear)
            begin
                hdr_reg        <= csb_pkg::HDR_NONE;
                kw_reg         <= csb_pkg::KW_IDLE;
                paren_reg      <= '0;
                depth_reg      <= '0;
                prev_ident_reg <= 1'b0;
                top_kind_reg   <= 1'b0;
            end
            else if (ctl.step)
            begin
                hdr_reg        <= hdr_next;
                kw_reg         <= kw_next;
                paren_reg      <= paren_next;
                depth_reg      <= depth_next;
                prev_ident_reg <= prev_ident_next;
                ovf_reg        <= ovf_next;
                top_kind_reg   <= top_kind_next;
            end
        end
    end

    assign loop_depth  = csb_pkg::LOOP_W'(depth_rep);
    assign final_depth = csb_pkg::LOOP_W'(depth_reg);
    assign overflow    = ctl.step ? ovf_next : ovf_reg;

endmodule

// ----- sv/c_source_blank_and_loop_depth.sv -----
// C source blanker with loop nesting depth: top level sequencer and registers.
// Instantiates csb_lexer and csb_depth; uses csb_pkg.
//
// Takes one source byte per cycle while byte_stall is low and returns each
// byte, with comments and literal contents blanked to spaces, together with
// the loop nesting depth at that byte. Each result leaves one request late
// because the lexer looks one byte ahead, so the first byte of a text gives no
// result. A byte marked last_char produces its own result and then an end
// result carrying the final depth; meanwhile a following request waits in the
// input register. Otherwise the block sustains one request per cycle while
// res_stall is low, and a byte passes from the input register through the
// held byte register to the result register. The brace stack is STACK_DEPTH
// deep; nest_overflow stays set until reset.
module c_source_blank_and_loop_depth
#(
    parameter int STACK_DEPTH = 64,
    parameter int PAREN_MAX   = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  csb_pkg::in_item_t  byte_item,
    output logic               res_valid,
    input  logic               res_stall,
    output csb_pkg::out_item_t res_item
);

    logic                        in_valid_reg;
    csb_pkg::in_item_t           in_item_reg;
    logic [csb_pkg::CHAR_W-1:0]  held_char_reg, held_char_next;
    logic                        held_valid_reg, held_valid_next;
    logic                        held_consumed_reg, held_consumed_next;
    csb_pkg::seq_phase_t         phase_reg, phase_next;
    logic                        res_valid_reg;
    csb_pkg::out_item_t          res_item_reg, res_item_next;

    csb_pkg::lex_ctl_t           lex_ctl;
    csb_pkg::depth_ctl_t         depth_ctl;
    logic [csb_pkg::CHAR_W-1:0]  blanked;
    logic                        eat;
    logic [csb_pkg::LOOP_W-1:0]  loop_depth;
    logic [csb_pkg::LOOP_W-1:0]  final_depth;
    logic                        overflow;

    logic out_free;
    logic produce;
    logic fire;
    logic in_take;
    logic accept;
    logic step;

    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        produce = 1'b1;
        fire    = 1'b0;
        step    = 1'b0;
        case (phase_reg)
            csb_pkg::PH_RUN:
            begin
                produce = held_valid_reg;
                fire    = in_valid_reg && (!held_valid_reg || out_free);
                step    = fire && held_valid_reg;
            end
            csb_pkg::PH_TAIL:
            begin
                fire = out_free;
                step = fire;
            end
            csb_pkg::PH_END:
            begin
                fire = out_free;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
    end

    assign in_take    = fire && (phase_reg == csb_pkg::PH_RUN);
    assign byte_stall = in_valid_reg && !in_take;
    assign accept     = byte_valid && !byte_stall;

    assign lex_ctl.step      = step;
    assign lex_ctl.clear     = fire && (phase_reg == csb_pkg::PH_END);
    assign lex_ctl.consumed  = held_consumed_reg;
    assign lex_ctl.has_next  = (phase_reg == csb_pkg::PH_RUN);
    assign depth_ctl.step    = step;
    assign depth_ctl.clear   = lex_ctl.clear;

    csb_lexer u_lexer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lex_ctl),
        .cur     (held_char_reg),
        .nxt     (in_item_reg.char_in),
        .blanked (blanked),
        .eat     (eat)
    );

    csb_depth
    #(
        .STACK_DEPTH (STACK_DEPTH),
        .PAREN_MAX   (PAREN_MAX)
    )
    u_depth
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (depth_ctl),
        .blanked     (blanked),
        .loop_depth  (loop_depth),
        .final_depth (final_depth),
        .overflow    (overflow)
    );

    always_comb
    begin
        held_char_next     = held_char_reg;
        held_valid_next    = held_valid_reg;
        held_consumed_next = held_consumed_reg;
        phase_next         = phase_reg;
        if (fire)
        begin
            case (phase_reg)
                csb_pkg::PH_RUN:
                begin
                    // The byte taken by an escape, comment opener or comment closer is
                    // held already blanked.
                    held_consumed_next = eat && held_valid_reg;
                    held_char_next     = held_consumed_next ? csb_pkg::CH_SPACE
                                                            : in_item_reg.char_in;
                    held_valid_next    = 1'b1;
                    if (in_item_reg.last_char)
                    begin
                        phase_next = csb_pkg::PH_TAIL;
                    end
                end
                csb_pkg::PH_TAIL:
                begin
                    phase_next = csb_pkg::PH_END;
                end
                csb_pkg::PH_END:
                begin
                    held_char_next     = csb_pkg::CH_NUL;
                    held_valid_next    = 1'b0;
                    held_consumed_next = 1'b0;
                    phase_next         = csb_pkg::PH_RUN;
                end
                default:
                begin
                    phase_next = csb_pkg::PH_RUN;
                end
            endcase
        end
    end

    always_comb
    begin
        res_item_next.nest_overflow = overflow;
        if (phase_reg == csb_pkg::PH_END)
        begin
            res_item_next.char_out    = csb_pkg::CH_NUL;
            res_item_next.loop_depth  = final_depth;
            res_item_next.end_of_text = 1'b1;
        end
        else
        begin
            res_item_next.char_out    = blanked;
            res_item_next.loop_depth  = loop_depth;
            res_item_next.end_of_text = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            held_char_reg     <= '0;
            held_valid_reg    <= 1'b0;
            held_consumed_reg <= 1'b0;
            phase_reg         <= csb_pkg::PH_RUN;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (in_take)
            begin
                in_valid_reg <= 1'b0;
            end
            held_char_reg     <= held_char_next;
            held_valid_reg    <= held_valid_next;
            held_consumed_reg <= held_consumed_next;
            phase_reg         <= phase_next;
            if (fire && produce)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= byte_item;
        end
        if (fire && produce)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule
